// ----- rtl/core/permutation_swap_sequence_unit_macros.svh -----
// Assertion helpers for the swap sequence unit.
`ifndef PERMUTATION_SWAP_SEQUENCE_UNIT_MACROS_SVH
`define PERMUTATION_SWAP_SEQUENCE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pss assertion failed");
// next-cycle implication
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss assertion failed");
`else
`define PSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/pss_pkg.sv -----
`timescale 1ns / 1ps

package pss_pkg;

    localparam int CITY_W         = 6;
    localparam int POS_W          = 6;
    localparam int NUM_CITY       = 64;
    localparam int MAX_CITIES_DEF = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_RD,
        S_CMP,
        S_SWAP,
        S_END,
        S_EQ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic map_clr;
        logic clr_i;
        logic inc_i;
        logic build_rd;
        logic walk_rd;
        logic pos_rd;
        logic swap;
        logic end_push;
        logic eq_push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic final_item;
        logic equal_all;
        logic idx_last;
        logic diff;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/pss_ctrl.sv -----
`timescale 1ns / 1ps

module pss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pss_pkg::t_status  i_status,
    output pss_pkg::t_cmd     o_cmd
);

    pss_pkg::t_state r_state;
    pss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.final_item) begin
                        if (i_status.equal_all) begin
                            n_state = pss_pkg::S_EQ;
                        end else begin
                            o_cmd.map_clr = 1'b1;
                            o_cmd.clr_i   = 1'b1;
                            n_state       = pss_pkg::S_BUILD;
                        end
                    end
                end
            end
            pss_pkg::S_BUILD: begin
                o_cmd.build_rd = 1'b1;
                if (i_status.idx_last) begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = pss_pkg::S_RD;
                end else begin
                    o_cmd.inc_i = 1'b1;
                end
            end
            pss_pkg::S_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = pss_pkg::S_CMP;
            end
            pss_pkg::S_CMP: begin
                if (i_status.diff) begin
                    o_cmd.pos_rd = 1'b1;
                    n_state      = pss_pkg::S_SWAP;
                end else if (i_status.idx_last) begin
                    n_state = pss_pkg::S_END;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = pss_pkg::S_RD;
                end
            end
            pss_pkg::S_SWAP: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.swap = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = pss_pkg::S_END;
                    end else begin
                        o_cmd.inc_i = 1'b1;
                        n_state     = pss_pkg::S_RD;
                    end
                end
            end
            pss_pkg::S_END: begin
                if (!i_status.pend_valid) begin
                    n_state = pss_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.end_push = 1'b1;
                    n_state        = pss_pkg::S_IDLE;
                end
            end
            pss_pkg::S_EQ: begin
                if (i_status.out_free) begin
                    o_cmd.eq_push = 1'b1;
                    n_state       = pss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pss_dp.sv -----
`timescale 1ns / 1ps

module pss_dp #(
    parameter int MAX_CITIES = pss_pkg::MAX_CITIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pss_pkg::t_cmd               i_cmd,
    output pss_pkg::t_status            o_status,
    input  logic [pss_pkg::CITY_W-1:0]  i_source_city,
    input  logic [pss_pkg::CITY_W-1:0]  i_target_city,
    input  logic                        i_final_element,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pss_pkg::POS_W-1:0]   o_first_position,
    output logic [pss_pkg::POS_W-1:0]   o_second_position,
    output logic                        o_swap_present,
    output logic                        o_final_swap
);

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CW = pss_pkg::CITY_W;

    // storage
    logic [CW-1:0] r_work_mem [MAX_CITIES];
    logic [CW-1:0] r_tgt_mem  [MAX_CITIES];
    logic [AW-1:0] r_pos_mem  [pss_pkg::NUM_CITY];
    logic [pss_pkg::NUM_CITY-1:0] r_mapped;

    // counters
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_i;
    logic          r_eq;

    // read data
    logic [CW-1:0] r_wk_rd;
    logic [CW-1:0] r_tg_rd;
    logic [AW-1:0] r_pos_rd;
    logic          r_pos_rv;

    // deferred map writes
    logic          r_bw_valid;
    logic [AW-1:0] r_bw_pos;
    logic          r_pw_valid;
    logic [CW-1:0] r_pw_addr;
    logic [AW-1:0] r_pw_data;

    // held-back result and output register
    logic          r_pend_valid;
    logic [AW-1:0] r_pend_a;
    logic [AW-1:0] r_pend_b;
    logic          r_out_valid;
    logic [AW-1:0] r_out_a;
    logic [AW-1:0] r_out_b;
    logic          r_out_sp;
    logic          r_out_fl;

    logic [AW-1:0] w_j;
    logic          w_pw_en;
    logic [CW-1:0] w_pw_addr;
    logic [AW-1:0] w_pw_data;

    // cities missing from the map sit at position zero
    assign w_j = r_pos_rv ? r_pos_rd : '0;

    always_comb begin
        w_pw_en   = 1'b0;
        w_pw_addr = r_wk_rd;
        w_pw_data = w_j;
        priority if (i_cmd.swap) begin
            w_pw_en = 1'b1;
        end else if (r_bw_valid) begin
            w_pw_en   = 1'b1;
            w_pw_data = r_bw_pos;
        end else if (r_pw_valid) begin
            w_pw_en   = 1'b1;
            w_pw_addr = r_pw_addr;
            w_pw_data = r_pw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work_mem[r_cnt] <= i_source_city;
        end else if (i_cmd.swap) begin
            r_work_mem[w_j] <= r_wk_rd;
        end
        if (i_cmd.build_rd || i_cmd.walk_rd) begin
            r_wk_rd <= r_work_mem[r_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt_mem[r_cnt] <= i_target_city;
        end
        if (i_cmd.walk_rd) begin
            r_tg_rd <= r_tgt_mem[r_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pw_en) begin
            r_pos_mem[w_pw_addr] <= w_pw_data;
        end
        if (i_cmd.pos_rd) begin
            r_pos_rd <= r_pos_mem[r_tg_rd];
            r_pos_rv <= r_mapped[r_tg_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped     <= '0;
            r_cnt        <= '0;
            r_i          <= '0;
            r_eq         <= 1'b1;
            r_bw_valid   <= 1'b0;
            r_pw_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.map_clr) begin
                r_mapped <= '0;
            end else if (w_pw_en) begin
                r_mapped[w_pw_addr] <= 1'b1;
            end

            if (i_cmd.load) begin
                if (o_status.final_item) begin
                    r_cnt <= '0;
                    r_eq  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_eq  <= o_status.equal_all;
                end
            end

            if (i_cmd.clr_i) begin
                r_i <= '0;
            end else if (i_cmd.inc_i) begin
                r_i <= r_i + 1'b1;
            end

            r_bw_valid <= i_cmd.build_rd;
            r_pw_valid <= i_cmd.swap;

            if (i_cmd.swap) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.end_push) begin
                r_pend_valid <= 1'b0;
            end

            if ((i_cmd.swap && r_pend_valid) || i_cmd.end_push || i_cmd.eq_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && o_status.final_item) begin
            r_last <= r_cnt;
        end
        r_bw_pos  <= r_i;
        r_pw_addr <= r_tg_rd;
        r_pw_data <= r_i;
        if (i_cmd.swap) begin
            r_pend_a <= r_i;
            r_pend_b <= w_j;
        end
        priority if (i_cmd.swap && r_pend_valid) begin
            r_out_a  <= r_pend_a;
            r_out_b  <= r_pend_b;
            r_out_sp <= 1'b1;
            r_out_fl <= 1'b0;
        end else if (i_cmd.end_push) begin
            r_out_a  <= r_pend_a;
            r_out_b  <= r_pend_b;
            r_out_sp <= 1'b1;
            r_out_fl <= 1'b1;
        end else if (i_cmd.eq_push) begin
            r_out_a  <= '0;
            r_out_b  <= '0;
            r_out_sp <= 1'b0;
            r_out_fl <= 1'b1;
        end
    end

    assign o_status.final_item = i_final_element || (r_cnt == AW'(MAX_CITIES - 1));
    assign o_status.equal_all  = r_eq && (i_source_city == i_target_city);
    assign o_status.idx_last   = (r_i == r_last);
    assign o_status.diff       = (r_wk_rd != r_tg_rd);
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_first_position  = pss_pkg::POS_W'(r_out_a);
    assign o_second_position = pss_pkg::POS_W'(r_out_b);
    assign o_swap_present    = r_out_sp;
    assign o_final_swap      = r_out_fl;

endmodule

// ----- rtl/core/permutation_swap_sequence_unit.sv -----
`timescale 1ns / 1ps
// Swap sequence unit: load a source and a target permutation one position per
// transaction (tlast on the last position, or automatically at MAX_CITIES
// positions), then read out the swaps that turn source into target, lowest
// position first, tlast on the final swap. Equal permutations give a single
// transaction with tuser low. After the last position, the unit builds the
// city-to-position map, one position at a time, then walks the positions: it
// reads each one, compares it and, where the cities differ, reads the map and
// swaps; a closing step flushes the last swap. A swap or the closing step waits
// while the output side stalls. This ordering comes from the single-ported working,
// target and map memories. Input is accepted only between sequences.

`include "permutation_swap_sequence_unit_macros.svh"

module permutation_swap_sequence_unit #(
    parameter int MAX_CITIES = pss_pkg::MAX_CITIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [5:0] source_city, [11:6] target_city, rest 0
    input  logic        i_s_axis_tlast,   // final_element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [5:0] first_position, [11:6] second_position
    output logic [0:0]  o_m_axis_tuser,   // [0] swap_present
    output logic        o_m_axis_tlast    // final_swap
);

    pss_pkg::t_cmd    w_cmd;
    pss_pkg::t_status w_status;

    logic [pss_pkg::POS_W-1:0] w_first;
    logic [pss_pkg::POS_W-1:0] w_second;
    logic                      w_swap_present;

    // sequencing: load / build map / walk / flush last result
    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // memories, counters and the result registers
    pss_dp #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_source_city     (i_s_axis_tdata[5:0]),
        .i_target_city     (i_s_axis_tdata[11:6]),
        .i_final_element   (i_s_axis_tlast),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_first_position  (w_first),
        .o_second_position (w_second),
        .o_swap_present    (w_swap_present),
        .o_final_swap      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata    = {4'b0000, w_second, w_first};
    assign o_m_axis_tuser[0] = w_swap_present;

    // a new sequence never starts with a swap still held back
    `PSS_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, o_s_axis_tready, !w_status.pend_valid)
    // every swap leaves a result held back for the flush
    `PSS_ASSERT_NXT(a_swap_pend, i_clk, i_rst_n, w_cmd.swap, w_status.pend_valid)
    // the no-swap result is always the only and last one
    `PSS_ASSERT_IMP(a_noswap_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0],
                    o_m_axis_tlast)

endmodule

// ----- bench/permutation_swap_sequence_unit_tb.sv -----
`timescale 1ns / 1ps

module permutation_swap_sequence_unit_tb;

    localparam int CITY_W       = pss_pkg::CITY_W;
    localparam int POS_W        = pss_pkg::POS_W;
    localparam int NUM_CITY     = pss_pkg::NUM_CITY;
    localparam int MAX_CITIES   = pss_pkg::MAX_CITIES_DEF;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 200;   // quiet time after the last expected swap

    typedef struct packed {
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] second_pos;
        logic             swap_present;
        logic             final_swap;
    } t_swap;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;   // [5:0] source_city, [11:6] target_city
    logic        i_s_axis_tlast  = 1'b0; // final_element
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [5:0] first_position, [11:6] second_position
    logic [0:0]  o_m_axis_tuser;         // [0] swap_present
    logic        o_m_axis_tlast;         // final_swap

    int src_idle_pct  = 26;
    int snk_stall_pct = 56;

    int err_count       = 0;
    int items_sent      = 0;
    int sequences_sent  = 0;
    int swaps_checked   = 0;
    int no_swap_checked = 0;
    int quiet_cycles    = 0;

    // predictor state
    logic [CITY_W-1:0] work_perm [NUM_CITY];
    logic [CITY_W-1:0] tgt_store [NUM_CITY];
    logic [POS_W-1:0]  city_pos  [NUM_CITY];
    int                load_count = 0;
    t_swap             expected_swaps [$];

    // stimulus buffers for one sequence
    logic [CITY_W-1:0] seq_src [NUM_CITY];
    logic [CITY_W-1:0] seq_tgt [NUM_CITY];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    permutation_swap_sequence_unit #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Store one position; on the closing one, work out the whole swap list.
    task automatic predict_swaps(input logic [CITY_W-1:0] src, input logic [CITY_W-1:0] tgt,
                                 input logic fin);
        int                idx;
        int                n;
        int                k;
        bit                same;
        logic [CITY_W-1:0] want;
        logic [CITY_W-1:0] here;
        logic [POS_W-1:0]  j;
        t_swap             one_res;
        t_swap             seq_res [NUM_CITY];
        idx = load_count & 63;
        work_perm[idx] = src;
        tgt_store[idx] = tgt;
        n = idx + 1;
        if (!fin && n < MAX_CITIES) begin
            load_count = n;
            return;
        end
        load_count = 0;
        same = 1'b1;
        for (int i = 0; i < n; i++)
            if (work_perm[i] != tgt_store[i]) same = 1'b0;
        if (same) begin
            one_res = '{first_pos: '0, second_pos: '0, swap_present: 1'b0, final_swap: 1'b1};
            expected_swaps = {expected_swaps, one_res};
            return;
        end
        // map is cleared first: a city missing from the source sits at position 0,
        // and with duplicates the last occurrence wins
        for (int c = 0; c < NUM_CITY; c++) city_pos[c] = '0;
        for (int i = 0; i < n; i++) city_pos[work_perm[i]] = POS_W'(i);
        k = 0;
        for (int i = 0; i < n; i++) begin
            want = tgt_store[i];
            here = work_perm[i];
            if (want != here) begin
                j = city_pos[want];
                work_perm[i] = want;
                work_perm[j] = here;
                city_pos[here] = j;
                city_pos[want] = POS_W'(i);
                seq_res[k] = '{first_pos: POS_W'(i), second_pos: j,
                               swap_present: 1'b1, final_swap: 1'b0};
                k++;
            end
        end
        if (k > 0) seq_res[k-1].final_swap = 1'b1;
        for (int i = 0; i < k; i++) expected_swaps = {expected_swaps, seq_res[i]};
    endtask

    // Receiver: random backpressure.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watches both sides: predicts on every input transaction, checks every output one.
    always @(posedge i_clk) begin : monitor
        t_swap       exp_swap;
        logic [15:0] exp_data;
        bit          in_txn;
        bit          out_txn;
        if (i_rst_n) begin
            in_txn  = i_s_axis_tvalid && o_s_axis_tready;
            out_txn = o_m_axis_tvalid && i_m_axis_tready;
            if (in_txn)
                predict_swaps(i_s_axis_tdata[5:0], i_s_axis_tdata[11:6], i_s_axis_tlast);
            if (out_txn) begin
                if (expected_swaps.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected swap: first=%0d second=%0d present=%0b last=%0b",
                             $time, o_m_axis_tdata[5:0], o_m_axis_tdata[11:6],
                             o_m_axis_tuser[0], o_m_axis_tlast);
                end else begin
                    exp_swap = expected_swaps.pop_front();
                    exp_data = {4'b0, exp_swap.second_pos, exp_swap.first_pos};
                    if (o_m_axis_tdata !== exp_data ||
                        o_m_axis_tuser[0] !== exp_swap.swap_present ||
                        o_m_axis_tlast !== exp_swap.final_swap) begin
                        err_count++;
                        $display("%0t: swap mismatch: expected first=%0d second=%0d %s",
                                 $time, exp_swap.first_pos, exp_swap.second_pos,
                                 $sformatf("present=%0b last=%0b pad=0",
                                           exp_swap.swap_present, exp_swap.final_swap));
                        $display("%0t:                actual   first=%0d second=%0d %s",
                                 $time, o_m_axis_tdata[5:0], o_m_axis_tdata[11:6],
                                 $sformatf("present=%0b last=%0b pad=%0h",
                                           o_m_axis_tuser[0], o_m_axis_tlast,
                                           o_m_axis_tdata[15:12]));
                    end
                    swaps_checked++;
                    if (!exp_swap.swap_present) no_swap_checked++;
                end
            end
            if (in_txn || out_txn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d swaps outstanding",
                         $time, STALL_LIMIT, expected_swaps.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // One input transaction. Called at a clock edge; returns at the edge it is taken.
    task automatic send_position(input logic [CITY_W-1:0] src, input logic [CITY_W-1:0] tgt,
                                 input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, tgt, src};
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // tlast only on the closing position; at full length it is left to close_flag
    task automatic send_sequence(input int n, input logic close_flag);
        for (int p = 0; p < n; p++)
            send_position(seq_src[p], seq_tgt[p], (p == n - 1) ? close_flag : 1'b0);
        sequences_sent++;
    endtask

    // n distinct random cities into the source
    task automatic fill_distinct(input int n);
        logic [CITY_W-1:0] pool [NUM_CITY];
        logic [CITY_W-1:0] tmp;
        int                r;
        for (int c = 0; c < NUM_CITY; c++) pool[c] = CITY_W'(c);
        for (int c = NUM_CITY - 1; c > 0; c--) begin
            r = $urandom_range(c);
            tmp = pool[c]; pool[c] = pool[r]; pool[r] = tmp;
        end
        for (int p = 0; p < n; p++) seq_src[p] = pool[p];
    endtask

    // target = random rearrangement of the source
    task automatic shuffle_target(input int n);
        logic [CITY_W-1:0] tmp;
        int                r;
        for (int p = 0; p < n; p++) seq_tgt[p] = seq_src[p];
        for (int p = n - 1; p > 0; p--) begin
            r = $urandom_range(p);
            tmp = seq_tgt[p]; seq_tgt[p] = seq_tgt[r]; seq_tgt[r] = tmp;
        end
    endtask

    task automatic test_equal_permutations();
        seq_src[0] = 6'd0;  seq_tgt[0] = 6'd0;
        seq_src[1] = 6'd63; seq_tgt[1] = 6'd63;
        send_sequence(2, 1'b1);
    endtask

    task automatic test_single_position();
        seq_src[0] = 6'd63; seq_tgt[0] = 6'd0;   // lone mismatch: swaps position 0 with itself
        send_sequence(1, 1'b1);
        seq_src[0] = 6'd21; seq_tgt[0] = 6'd21;
        send_sequence(1, 1'b1);
    endtask

    task automatic test_reversal();
        logic [CITY_W-1:0] cities [6] = '{6'd0, 6'd63, 6'd21, 6'd42, 6'd7, 6'd56};
        for (int p = 0; p < 6; p++) begin
            seq_src[p] = cities[p];
            seq_tgt[p] = cities[5 - p];
        end
        send_sequence(6, 1'b1);
    endtask

    task automatic test_rotation();
        logic [CITY_W-1:0] cities [4] = '{6'd12, 6'd51, 6'd3, 6'd44};
        for (int p = 0; p < 4; p++) begin
            seq_src[p] = cities[p];
            seq_tgt[p] = cities[(p + 1) % 4];
        end
        send_sequence(4, 1'b1);
    endtask

    // duplicates in the source, and a target city the source never holds
    task automatic test_non_permutation();
        logic [CITY_W-1:0] src [5] = '{6'd9, 6'd9, 6'd30, 6'd1, 6'd1};
        logic [CITY_W-1:0] tgt [5] = '{6'd30, 6'd2, 6'd9, 6'd1, 6'd63};
        for (int p = 0; p < 5; p++) begin
            seq_src[p] = src[p];
            seq_tgt[p] = tgt[p];
        end
        send_sequence(5, 1'b1);
    endtask

    // full length with tlast never set: the block must close the sequence itself
    task automatic test_length_limit();
        fill_distinct(MAX_CITIES);
        shuffle_target(MAX_CITIES);
        send_sequence(MAX_CITIES, 1'b0);
    endtask

    // Mostly well-formed pairs over random city subsets, some equal pairs, some noise.
    task automatic test_random_sequences(input int item_budget);
        int start_items;
        int n;
        int kind;
        bit dup_heavy;
        start_items = items_sent;
        while (items_sent - start_items < item_budget) begin
            n = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            kind = $urandom_range(99);
            if (kind < 70) begin
                fill_distinct(n);
                shuffle_target(n);
            end else if (kind < 80) begin
                fill_distinct(n);
                for (int p = 0; p < n; p++) seq_tgt[p] = seq_src[p];
            end else begin
                dup_heavy = $urandom_range(1);
                for (int p = 0; p < n; p++) begin
                    seq_src[p] = dup_heavy ? CITY_W'($urandom_range(3)) :
                                             CITY_W'($urandom_range(63));
                    seq_tgt[p] = CITY_W'($urandom_range(63));
                end
            end
            send_sequence(n, 1'b1);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver stalls heavily
        src_idle_pct  = 26;
        snk_stall_pct = 56;
        test_equal_permutations();
        test_single_position();
        test_reversal();
        test_rotation();
        test_non_permutation();
        test_length_limit();
        test_random_sequences(40);

        // the other way round
        src_idle_pct  = 56;
        snk_stall_pct = 26;
        test_random_sequences(40);

        // back to back
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        test_random_sequences(40);

        i_s_axis_tvalid <= 1'b0;
        while (expected_swaps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Loaded %0d positions in %0d sequences, incl. one closed by length alone.",
                 items_sent, sequences_sent);
        $display("Checked %0d swap transactions, %0d of them no-swap, %0d errors.",
                 swaps_checked, no_swap_checked, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
